[hdl/htrp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htrp_pkg
// Shared types and constants of the heat-tiered residency policy block.
// ---------------------------------------------------------------------------
package htrp_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int SIZE_W          = 40;
    localparam int HEAT_W          = 32;
    localparam int TOKEN_W         = 48;
    localparam int RATE_W          = 31;
    localparam int ELAPSED_W       = 40;
    localparam int LIMIT_W         = 11;
    localparam int DECAY_W         = 16;
    localparam int TARGET_W        = 20;
    localparam int IDX_W           = 8;
    localparam int HEAT_STEP       = 10;
    localparam int RATE_SCALE      = 100;
    localparam int MIB_SHIFT       = 20;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ACCESS = 2'd1;
    localparam logic [1:0] KIND_TOKEN  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCESS,
        ST_DIV,
        ST_DECAY_RD,
        ST_DECAY_WR,
        ST_PICK_RD,
        ST_PICK_CMP,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_DONE
    } state_t;

    // divider control and status of the long-division unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

[hdl/heat_tiered_residency_policy.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heat_tiered_residency_policy
// Heat-ranked residency policy over a table of sized entries.
// ---------------------------------------------------------------------------
// Each input beat gives exactly one result beat. Load and token beats pass
// through ST_READ to ST_DONE, in-range access beats also through ST_ACCESS
// (one table memory read, then write). A tick runs the rate division on a
// bit-serial divider when the elapsed time is nonzero, decays every loaded
// entry with a read and a write state per entry, and when it rebalances ranks
// by repeated selection: for each of the N loaded entries one scan of the
// loaded entries for the hottest unplaced entry; the table memory's single
// read port serializes these reads. The input side is not ready while a beat
// is in work; the result register holds until taken.
// ---------------------------------------------------------------------------
module heat_tiered_residency_policy
#(
    parameter int MAX_ENTRIES = htrp_pkg::MAX_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: index[7:0], entry_bytes[47:8], elapsed_ms[87:48]
    input  logic [87:0]  s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: found[0], resident[1], rate_x100[32:2], rebalanced[33],
    //        entry_total[42:34], zero pad
    output logic [47:0]  m_tdata
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = htrp_pkg::SIZE_W;
    localparam int HW = htrp_pkg::HEAT_W;
    localparam int UW = SW + AW + 1;

    // table memories
    logic [SW-1:0] size_mem [MAX_ENTRIES];
    logic [HW-1:0] heat_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hot_reg, hot_next;
    logic [MAX_ENTRIES-1:0] placed_reg, placed_next;

    logic [SW-1:0] size_rd;
    logic [HW-1:0] heat_rd;
    logic [AW-1:0] rd_addr;
    logic          heat_we;
    logic [AW-1:0] heat_waddr;
    logic [HW-1:0] heat_wdata;

    htrp_pkg::state_t state_reg, state_next;

    logic [htrp_pkg::LIMIT_W-1:0]  limit_reg;
    logic [htrp_pkg::DECAY_W-1:0]  decay_reg;
    logic [htrp_pkg::TARGET_W-1:0] target_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [htrp_pkg::TOKEN_W-1:0]  token_reg, token_next;
    logic [htrp_pkg::RATE_W-1:0]   rate_reg, rate_next;

    logic [1:0]                      kind_reg;
    logic [htrp_pkg::IDX_W-1:0]      idx_reg;
    logic                            last_reg;
    logic [htrp_pkg::ELAPSED_W-1:0]  elapsed_reg;

    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic [AW-1:0] best_reg, best_next;
    logic [HW-1:0] besth_reg, besth_next;
    logic          bestv_reg, bestv_next;
    logic [UW-1:0] used_reg, used_next;

    logic        out_valid_reg, out_valid_next;
    logic        found_reg, found_next;
    logic        res_reg, res_next;
    logic        reb_reg, reb_next;

    logic        div_start;
    htrp_pkg::div_ctl_t div_ctl;
    logic [htrp_pkg::RATE_W-1:0] div_q;
    logic [htrp_pkg::TOKEN_W+6:0] div_num;

    logic [UW-1:0]  limit_bytes;
    logic [UW-1:0]  used_sum;
    logic [HW-1:0]  heat_inc;
    logic [HW-1:0]  heat_dec;
    logic           in_range;
    logic           rebal_go;
    logic [AW-1:0]  ptr_a;
    logic [AW-1:0]  idx_a;

    assign ptr_a = ptr_reg[AW-1:0];
    assign idx_a = AW'(idx_reg);
    assign in_range = ({1'b0, idx_reg} < 9'(count_reg)) && (32'(idx_reg) < MAX_ENTRIES);
    assign limit_bytes = UW'({limit_reg, {htrp_pkg::MIB_SHIFT{1'b0}}});
    assign used_sum = used_reg + UW'(size_rd);
    assign heat_inc = (heat_rd > HW'(32'hFFFF_FFFF - htrp_pkg::HEAT_STEP))
                    ? {HW{1'b1}} : heat_rd + HW'(htrp_pkg::HEAT_STEP);
    assign heat_dec = (heat_rd > HW'(decay_reg)) ? heat_rd - HW'(decay_reg) : '0;
    assign rebal_go = 47'(rate_reg) <
                      47'(target_reg) * 47'(htrp_pkg::RATE_SCALE);
    assign div_num  = 55'(token_reg) * 55'(htrp_pkg::RATE_SCALE);

    // configuration port
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[3:2])
            htrp_pkg::REG_LIMIT:  prdata = 32'(limit_reg);
            htrp_pkg::REG_DECAY:  prdata = 32'(decay_reg);
            htrp_pkg::REG_TARGET: prdata = 32'(target_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= htrp_pkg::LIMIT_W'(512);
            decay_reg  <= htrp_pkg::DECAY_W'(1);
            target_reg <= htrp_pkg::TARGET_W'(10);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                htrp_pkg::REG_LIMIT:  limit_reg  <= pwdata[htrp_pkg::LIMIT_W-1:0];
                htrp_pkg::REG_DECAY:  decay_reg  <= pwdata[htrp_pkg::DECAY_W-1:0];
                htrp_pkg::REG_TARGET: target_reg <= pwdata[htrp_pkg::TARGET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    htrp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (elapsed_reg),
        .ctl      (div_ctl),
        .quotient (div_q)
    );

    // table memory ports
    always_ff @(posedge clk)
    begin
        size_rd <= size_mem[rd_addr];
        heat_rd <= heat_mem[rd_addr];
        if (heat_we)
            heat_mem[heat_waddr] <= heat_wdata;
        if (state_reg == htrp_pkg::ST_IDLE && s_tvalid && s_tuser == htrp_pkg::KIND_LOAD
            && 32'(s_tdata[7:0]) < MAX_ENTRIES)
            size_mem[AW'(s_tdata[7:0])] <= s_tdata[47:8];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            htrp_pkg::ST_IDLE:
                if (s_tvalid && s_tready)
                    state_next = htrp_pkg::ST_READ;
            htrp_pkg::ST_READ:
                unique case (kind_reg)
                    htrp_pkg::KIND_ACCESS: state_next = in_range ? htrp_pkg::ST_ACCESS
                                                                 : htrp_pkg::ST_DONE;
                    htrp_pkg::KIND_TICK:   state_next = (elapsed_reg != '0)
                                                      ? htrp_pkg::ST_DIV
                                                      : htrp_pkg::ST_DECAY_RD;
                    default:               state_next = htrp_pkg::ST_DONE;
                endcase
            htrp_pkg::ST_ACCESS:
                state_next = htrp_pkg::ST_DONE;
            htrp_pkg::ST_DIV:
                if (div_ctl.done)
                    state_next = htrp_pkg::ST_DECAY_RD;
            htrp_pkg::ST_DECAY_RD:
                if (ptr_reg >= count_reg)
                    state_next = rebal_go ? htrp_pkg::ST_PICK_RD : htrp_pkg::ST_DONE;
                else
                    state_next = htrp_pkg::ST_DECAY_WR;
            htrp_pkg::ST_DECAY_WR:
                state_next = htrp_pkg::ST_DECAY_RD;
            htrp_pkg::ST_PICK_RD:
                if (pass_reg >= count_reg)
                    state_next = htrp_pkg::ST_DONE;
                else if (ptr_reg >= count_reg)
                    state_next = htrp_pkg::ST_PLACE_RD;
                else
                    state_next = htrp_pkg::ST_PICK_CMP;
            htrp_pkg::ST_PICK_CMP:
                state_next = htrp_pkg::ST_PICK_RD;
            htrp_pkg::ST_PLACE_RD:
                state_next = htrp_pkg::ST_PLACE_WR;
            htrp_pkg::ST_PLACE_WR:
                state_next = htrp_pkg::ST_PICK_RD;
            htrp_pkg::ST_DONE:
                if (!out_valid_reg || m_tready)
                    state_next = htrp_pkg::ST_IDLE;
            default:
                state_next = htrp_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb
    begin
        count_next     = count_reg;
        token_next     = token_reg;
        rate_next      = rate_reg;
        hot_next       = hot_reg;
        placed_next    = placed_reg;
        ptr_next       = ptr_reg;
        pass_next      = pass_reg;
        best_next      = best_reg;
        besth_next     = besth_reg;
        bestv_next     = bestv_reg;
        used_next      = used_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        reb_next       = reb_reg;
        out_valid_next = out_valid_reg;
        rd_addr        = idx_a;
        heat_we        = 1'b0;
        heat_waddr     = idx_a;
        heat_wdata     = '0;
        div_start      = 1'b0;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            htrp_pkg::ST_IDLE:
            begin
                found_next = 1'b0;
                res_next   = 1'b0;
                reb_next   = 1'b0;
                ptr_next   = '0;
                pass_next  = '0;
                used_next  = '0;
            end
            htrp_pkg::ST_READ:
            begin
                unique case (kind_reg)
                    htrp_pkg::KIND_LOAD:
                        if (32'(idx_reg) < MAX_ENTRIES)
                        begin
                            heat_we          = 1'b1;
                            hot_next[idx_a]  = 1'b0;
                            count_next = last_reg ? CW'({1'b0, idx_reg} + 9'd1) : '0;
                        end
                    htrp_pkg::KIND_TOKEN:
                        if (token_reg != {htrp_pkg::TOKEN_W{1'b1}})
                            token_next = token_reg + 1'b1;
                    htrp_pkg::KIND_TICK:
                        div_start = (elapsed_reg != '0);
                    default:
                    begin
                    end
                endcase
            end
            htrp_pkg::ST_ACCESS:
            begin
                heat_we    = 1'b1;
                heat_wdata = heat_inc;
                found_next = 1'b1;
                if (size_rd != '0)
                    hot_next[idx_a] = 1'b1;
                res_next = (size_rd != '0) | hot_reg[idx_a];
            end
            htrp_pkg::ST_DIV:
                if (div_ctl.done)
                    rate_next = div_q;
            htrp_pkg::ST_DECAY_RD:
            begin
                rd_addr     = ptr_a;
                placed_next = '0;
                bestv_next  = 1'b0;
                if (ptr_reg >= count_reg)
                begin
                    ptr_next = '0;
                    reb_next = rebal_go;
                end
            end
            htrp_pkg::ST_DECAY_WR:
            begin
                heat_we    = 1'b1;
                heat_waddr = ptr_a;
                heat_wdata = heat_dec;
                ptr_next   = ptr_reg + 1'b1;
            end
            htrp_pkg::ST_PICK_RD:
                rd_addr = ptr_a;
            htrp_pkg::ST_PICK_CMP:
            begin
                // strict compare keeps the lower index on equal heat
                if (!placed_reg[ptr_a] && (!bestv_reg || heat_rd > besth_reg))
                begin
                    best_next  = ptr_a;
                    besth_next = heat_rd;
                    bestv_next = 1'b1;
                end
                ptr_next = ptr_reg + 1'b1;
            end
            htrp_pkg::ST_PLACE_RD:
                rd_addr = best_reg;
            htrp_pkg::ST_PLACE_WR:
            begin
                rd_addr = best_reg;
                placed_next[best_reg] = 1'b1;
                if (used_sum <= limit_bytes)
                begin
                    if (size_rd != '0)
                        hot_next[best_reg] = 1'b1;
                    used_next = used_sum;
                end
                else
                    hot_next[best_reg] = 1'b0;
                bestv_next = 1'b0;
                ptr_next   = '0;
                pass_next  = pass_reg + 1'b1;
            end
            htrp_pkg::ST_DONE:
                if (!out_valid_reg || m_tready)
                    out_valid_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htrp_pkg::ST_IDLE;
            count_reg     <= '0;
            token_reg     <= '0;
            rate_reg      <= '0;
            hot_reg       <= '0;
            placed_reg    <= '0;
            ptr_reg       <= '0;
            pass_reg      <= '0;
            bestv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            token_reg     <= token_next;
            rate_reg      <= rate_next;
            hot_reg       <= hot_next;
            placed_reg    <= placed_next;
            ptr_reg       <= ptr_next;
            pass_reg      <= pass_next;
            bestv_reg     <= bestv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the beat fields and working payload
    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        besth_reg <= besth_next;
        used_reg  <= used_next;
        found_reg <= found_next;
        res_reg   <= res_next;
        reb_reg   <= reb_next;
        if (s_tvalid && s_tready)
        begin
            kind_reg    <= s_tuser;
            idx_reg     <= s_tdata[7:0];
            last_reg    <= s_tlast;
            elapsed_reg <= s_tdata[87:48];
        end
    end

    // result register, loaded when the work is done
    logic [47:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == htrp_pkg::ST_DONE && (!out_valid_reg || m_tready))
            out_reg <= {5'd0, 9'(count_reg), reb_reg, rate_reg, res_reg, found_reg};
    end

    assign s_tready = (state_reg == htrp_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule

[hdl/htrp_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htrp_div
// Restoring divider, one quotient bit per cycle; result saturated to the
// rate width.
// ---------------------------------------------------------------------------
module htrp_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [htrp_pkg::TOKEN_W+6:0]         dividend,
    input  logic [htrp_pkg::ELAPSED_W-1:0]       divisor,
    output htrp_pkg::div_ctl_t                   ctl,
    output logic [htrp_pkg::RATE_W-1:0]          quotient
);
    localparam int NW = htrp_pkg::TOKEN_W + 7;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]                  num_reg, num_next;
    logic [htrp_pkg::ELAPSED_W-1:0] rem_reg, rem_next;
    logic [NW-1:0]                  quo_reg, quo_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [htrp_pkg::ELAPSED_W:0]   shifted;

    // shift in one dividend bit and try a subtract
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, num_reg[NW-1]};
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = htrp_pkg::ELAPSED_W'(shifted - {1'b0, divisor});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[htrp_pkg::ELAPSED_W-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = (|quo_reg[NW-1:htrp_pkg::RATE_W]) ? {htrp_pkg::RATE_W{1'b1}}
                                                         : quo_reg[htrp_pkg::RATE_W-1:0];
endmodule
